// File: hdl/bsb_pkg.sv
// shared constants, types and entry format for the b-spline to bezier stream
package bsb_pkg;

  // spline length limit and point counter width
  localparam int MAX_POINTS = 32;
  localparam int CNT_W      = $clog2(MAX_POINTS);

  // decoupling queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // field and state widths
  localparam int PT_W   = 16;  // input offset
  localparam int B_W    = 17;  // point, doubled where it applies
  localparam int K_W    = 24;  // running position
  localparam int Q2_W   = 25;  // twice the midpoint
  localparam int PREV_W = 18;  // previous point
  localparam int OUT_W  = 19;  // emitted motion
  localparam int N_W    = 28;  // numerator of the divide by six
  localparam int U_W    = N_W - 1;  // halved magnitude of the numerator
  localparam int X3_W   = 25;  // curve end point
  localparam int X_W    = 27;  // control points and vector arithmetic

  // divide by three as multiply by reciprocal, exact for operands below 2^32
  localparam logic [31:0] RECIP3   = 32'hAAAAAAAB;
  localparam int          RECIP_SH = 33;
  localparam int          P_W      = U_W + 32;
  localparam int          Q_W      = P_W - RECIP_SH;

  // kind of queue entry
  typedef enum logic [1:0] {
    ENT_OPEN = 2'b01,
    ENT_SEG  = 2'b10
  } ent_kind_t;

  // one queued point, already classified and scaled
  typedef struct packed {
    ent_kind_t               kind;
    logic signed [B_W-1:0]   bx;
    logic signed [B_W-1:0]   by;
  } q_entry_t;

  // emit phase of the three vectors of a segment
  typedef enum logic [2:0] {
    PH_0 = 3'b001,
    PH_1 = 3'b010,
    PH_2 = 3'b100
  } phase_t;

endpackage

// File: hdl/bsb_front.sv
// front end: accepts control points, tracks the spline length and classifies points
module bsb_front import bsb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [PT_W-1:0] in_point_dx,
  input  logic signed [PT_W-1:0] in_point_dy,
  input  logic                   in_final_point,
  output logic                   push_valid,
  output q_entry_t               push_entry,
  input  logic                   push_ready
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             opening;
  logic             last;
  logic             accept;
  logic signed [B_W-1:0] px, py;

  // classify the current point
  assign opening  = (cnt_r == '0);
  assign last     = in_final_point ||
                    ({1'b0, cnt_r} >= (CNT_W+1)'(MAX_POINTS - 1));
  assign in_stall = !push_ready;
  assign accept   = in_valid && push_ready;

  // a lone opening point is dropped without a queue entry
  assign push_valid = in_valid && !(opening && in_final_point);

  // build the entry, doubling the final point of a spline
  assign px = B_W'(in_point_dx);
  assign py = B_W'(in_point_dy);
  always_comb begin
    if (opening) begin
      push_entry.kind = ENT_OPEN;
      push_entry.bx   = px;
      push_entry.by   = py;
    end else begin
      push_entry.kind = ENT_SEG;
      push_entry.bx   = last ? (px <<< 1) : px;
      push_entry.by   = last ? (py <<< 1) : py;
    end
  end

  // point counter
  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      if (opening) begin
        cnt_nxt = in_final_point ? '0 : CNT_W'(1);
      end else begin
        cnt_nxt = last ? '0 : cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: hdl/bsb_queue.sv
// short fifo of classified points between front and back
module bsb_queue import bsb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  input  q_entry_t push_entry,
  output logic     push_ready,
  output logic     pop_valid,
  output q_entry_t pop_entry,
  input  logic     pop_ready
);

  q_entry_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != (QPTR_W+1)'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_entry  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (QPTR_W+1)'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - (QPTR_W+1)'(1);
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// File: hdl/bsb_back.sv
// back end: curve state, divide-by-six pipeline and vector emitter
module bsb_back import bsb_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    ent_valid,
  input  q_entry_t                ent,
  output logic                    ent_ready,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_step_dh,
  output logic signed [OUT_W-1:0] out_step_dv,
  output logic                    out_curve_end,
  output logic                    out_run_last
);

  // curve state, lane 0 is x and lane 1 is y
  logic signed [K_W-1:0]    k_r    [2];
  logic signed [Q2_W-1:0]   q2_r   [2];
  logic signed [PREV_W-1:0] prev_r [2];
  logic signed [K_W-1:0]    end_r  [2];

  // stage 1: numerators
  logic                     s1_v_r;
  logic signed [N_W-1:0]    s1_n1_r  [2];
  logic signed [N_W-1:0]    s1_n2_r  [2];
  logic signed [X3_W-1:0]   s1_x3_r  [2];
  logic signed [K_W-1:0]    s1_end_r [2];

  // stage 2: halved magnitudes
  logic                     s2_v_r;
  logic [U_W-1:0]           s2_u1_r  [2];
  logic [U_W-1:0]           s2_u2_r  [2];
  logic                     s2_sg1_r [2];
  logic                     s2_sg2_r [2];
  logic signed [X3_W-1:0]   s2_x3_r  [2];
  logic signed [K_W-1:0]    s2_end_r [2];

  // stage 3: quotients
  logic                     s3_v_r;
  logic [Q_W-1:0]           s3_q1_r  [2];
  logic [Q_W-1:0]           s3_q2_r  [2];
  logic                     s3_sg1_r [2];
  logic                     s3_sg2_r [2];
  logic signed [X3_W-1:0]   s3_x3_r  [2];
  logic signed [K_W-1:0]    s3_end_r [2];

  // stage 4: segment buffer
  logic                     s4_v_r;
  logic signed [X_W-1:0]    s4_x1_r  [2];
  logic signed [X_W-1:0]    s4_x2_r  [2];
  logic signed [X3_W-1:0]   s4_x3_r  [2];
  logic signed [K_W-1:0]    s4_end_r [2];

  // emitter and output register
  phase_t                   phase_r;
  logic                     out_v_r;
  logic signed [OUT_W-1:0]  out_dh_r, out_dv_r;
  logic                     out_end_r;

  logic s1_ready, s2_ready, s3_ready, s4_ready;
  logic emit_load, take_seg, take_open;

  logic signed [B_W-1:0]    b      [2];
  logic signed [B_W-1:0]    half_b [2];
  logic signed [N_W-1:0]    q2x3   [2];
  logic signed [N_W-1:0]    n1     [2];
  logic signed [N_W-1:0]    n2     [2];
  logic signed [X3_W-1:0]   x3     [2];
  logic [N_W-1:0]           mag1   [2];
  logic [N_W-1:0]           mag2   [2];
  logic [P_W-1:0]           prod1  [2];
  logic [P_W-1:0]           prod2  [2];
  logic signed [X_W-1:0]    va     [2];
  logic signed [X_W-1:0]    vb     [2];
  logic signed [X_W-1:0]    vd     [2];

  // pipeline flow control
  assign emit_load = s4_v_r && (!out_v_r || !out_stall);
  assign s4_ready  = !s4_v_r || (emit_load && (phase_r == PH_2));
  assign s3_ready  = !s3_v_r || s4_ready;
  assign s2_ready  = !s2_v_r || s3_ready;
  assign s1_ready  = !s1_v_r || s2_ready;
  assign ent_ready = (ent.kind == ENT_OPEN) || s1_ready;
  assign take_open = ent_valid && (ent.kind == ENT_OPEN);
  assign take_seg  = ent_valid && (ent.kind == ENT_SEG) && s1_ready;

  // segment arithmetic per lane
  assign b[0] = ent.bx;
  assign b[1] = ent.by;
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      // halve toward zero
      half_b[i] = (b[i] + $signed({{(B_W-1){1'b0}}, b[i][B_W-1]})) >>> 1;
      q2x3[i]   = (N_W'(q2_r[i]) <<< 1) + N_W'(q2_r[i]);
      n1[i]     = q2x3[i] + (N_W'(prev_r[i]) <<< 1);
      n2[i]     = q2x3[i] + (N_W'(prev_r[i]) <<< 1) + N_W'(prev_r[i]) + N_W'(b[i]);
      x3[i]     = X3_W'(k_r[i]) + X3_W'(half_b[i]);
      // magnitudes for the divider
      mag1[i]   = s1_n1_r[i][N_W-1] ? N_W'(-s1_n1_r[i]) : N_W'(s1_n1_r[i]);
      mag2[i]   = s1_n2_r[i][N_W-1] ? N_W'(-s1_n2_r[i]) : N_W'(s1_n2_r[i]);
      // floor of u / 3
      prod1[i]  = P_W'(s2_u1_r[i]) * P_W'(RECIP3);
      prod2[i]  = P_W'(s2_u2_r[i]) * P_W'(RECIP3);
    end
  end

  // curve state update at entry transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        k_r[i]    <= '0;
        q2_r[i]   <= '0;
        prev_r[i] <= '0;
        end_r[i]  <= '0;
      end
    end else if (take_open) begin
      for (int i = 0; i < 2; i++) begin
        k_r[i]    <= K_W'(b[i]);
        q2_r[i]   <= '0;
        prev_r[i] <= PREV_W'(b[i]) <<< 1;
        end_r[i]  <= '0;
      end
    end else if (take_seg) begin
      for (int i = 0; i < 2; i++) begin
        k_r[i]    <= k_r[i] + K_W'(b[i]);
        q2_r[i]   <= (Q2_W'(k_r[i]) <<< 1) + Q2_W'(b[i]);
        prev_r[i] <= PREV_W'(b[i]);
        end_r[i]  <= $signed(x3[i][K_W-1:0]);
      end
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (s1_ready) s1_v_r <= take_seg;
      if (s2_ready) s2_v_r <= s1_v_r;
      if (s3_ready) s3_v_r <= s2_v_r;
      if (s4_ready) s4_v_r <= s3_v_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      if (take_seg) begin
        s1_n1_r[i]  <= n1[i];
        s1_n2_r[i]  <= n2[i];
        s1_x3_r[i]  <= x3[i];
        s1_end_r[i] <= end_r[i];
      end
      if (s2_ready && s1_v_r) begin
        s2_u1_r[i]  <= mag1[i][N_W-1:1];
        s2_u2_r[i]  <= mag2[i][N_W-1:1];
        s2_sg1_r[i] <= s1_n1_r[i][N_W-1];
        s2_sg2_r[i] <= s1_n2_r[i][N_W-1];
        s2_x3_r[i]  <= s1_x3_r[i];
        s2_end_r[i] <= s1_end_r[i];
      end
      if (s3_ready && s2_v_r) begin
        s3_q1_r[i]  <= prod1[i][RECIP_SH +: Q_W];
        s3_q2_r[i]  <= prod2[i][RECIP_SH +: Q_W];
        s3_sg1_r[i] <= s2_sg1_r[i];
        s3_sg2_r[i] <= s2_sg2_r[i];
        s3_x3_r[i]  <= s2_x3_r[i];
        s3_end_r[i] <= s2_end_r[i];
      end
      if (s4_ready && s3_v_r) begin
        s4_x1_r[i]  <= s3_sg1_r[i] ? -$signed(X_W'(s3_q1_r[i])) : $signed(X_W'(s3_q1_r[i]));
        s4_x2_r[i]  <= s3_sg2_r[i] ? -$signed(X_W'(s3_q2_r[i])) : $signed(X_W'(s3_q2_r[i]));
        s4_x3_r[i]  <= s3_x3_r[i];
        s4_end_r[i] <= s3_end_r[i];
      end
    end
  end

  // vector for the current phase
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      case (phase_r)
        PH_0: begin
          va[i] = s4_x1_r[i];
          vb[i] = X_W'(s4_end_r[i]);
        end
        PH_1: begin
          va[i] = s4_x2_r[i];
          vb[i] = s4_x1_r[i];
        end
        PH_2: begin
          va[i] = X_W'(s4_x3_r[i]);
          vb[i] = s4_x2_r[i];
        end
        default: begin
          va[i] = '0;
          vb[i] = '0;
        end
      endcase
      vd[i] = va[i] - vb[i];
    end
  end

  // emitter phase and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_0;
      out_v_r <= 1'b0;
    end else begin
      if (emit_load) begin
        out_v_r <= 1'b1;
        case (phase_r)
          PH_0:    phase_r <= PH_1;
          PH_1:    phase_r <= PH_2;
          PH_2:    phase_r <= PH_0;
          default: phase_r <= PH_0;
        endcase
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_dh_r  <= $signed(vd[0][OUT_W-1:0]);
      out_dv_r  <= $signed(vd[1][OUT_W-1:0]);
      out_end_r <= (phase_r == PH_2);
    end
  end

  assign out_valid     = out_v_r;
  assign out_step_dh   = out_dh_r;
  assign out_step_dv   = out_dv_r;
  assign out_curve_end = out_end_r;
  assign out_run_last  = out_end_r;

endmodule

// File: hdl/bspline_to_bezier_stream.sv
// top level of the quadratic b-spline to cubic bezier stream converter
//
// Takes relative control points of a quadratic B-spline and emits, for every
// point after the opening one, three relative motion vectors of a cubic
// Bezier segment; the third carries curve_end and run_last. A spline opening
// point or a lone point emits nothing. The output register sends one vector
// per cycle while out_stall is low; opening points cost no output slot. A
// segment point passes the four-entry queue (written at the transfer edge),
// then the numerator stage, magnitude stage, reciprocal multiply, segment
// buffer and output register before its first vector is presented. The
// input stalls only when the queue is full, and the output register
// decouples the result side, so either side may stall independently.
// Reaching MAX_POINTS points ends a spline as if the final flag were set.
module bspline_to_bezier_stream import bsb_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [PT_W-1:0]  in_point_dx,
  input  logic signed [PT_W-1:0]  in_point_dy,
  input  logic                    in_final_point,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_step_dh,
  output logic signed [OUT_W-1:0] out_step_dv,
  output logic                    out_curve_end,
  output logic                    out_run_last
);

  logic     push_valid, push_ready;
  q_entry_t push_entry;
  logic     pop_valid, pop_ready;
  q_entry_t pop_entry;

  // classification front end
  bsb_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_point_dx    (in_point_dx),
    .in_point_dy    (in_point_dy),
    .in_final_point (in_final_point),
    .push_valid     (push_valid),
    .push_entry     (push_entry),
    .push_ready     (push_ready)
  );

  // decoupling queue
  bsb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop_ready  (pop_ready)
  );

  // conversion back end
  bsb_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .ent_valid     (pop_valid),
    .ent           (pop_entry),
    .ent_ready     (pop_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_step_dh   (out_step_dh),
    .out_step_dv   (out_step_dv),
    .out_curve_end (out_curve_end),
    .out_run_last  (out_run_last)
  );

`ifndef SYNTHESIS
  // a segment's remaining vectors follow its first and second without a gap
  a_segment_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_curve_end) |=> out_valid)
    else $error("segment vectors interrupted");

  // reset leaves no result pending
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // reset leaves the queue empty, so the input is open
  a_reset_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

  // an entry is handed to the back only while the queue holds one
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && pop_ready) |-> $past(push_valid && push_ready) || $past(pop_valid))
    else $error("queue popped while empty");
`endif

endmodule
